@@ rtl/rtnh_pkg.sv @@
// ----------------------------------------------------------------------------
// rtnh_pkg: shared types and constants for the nearest-hit ray/triangle core
// Fixed point formats, beat payloads, microcode table and saturation helpers.
// ----------------------------------------------------------------------------
package rtnh_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int INDEX_WIDTH = 16;

    localparam int DIST_WIDTH = COORD_WIDTH - 1;
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    // truncated product plus headroom for a three-term sum
    localparam int ACC_WIDTH  = 2 * COORD_WIDTH - FRAC_BITS + 2;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int NUM_REGS = 6;

    localparam int EPS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int EPS_INT = (EPS_RAW > 0) ? EPS_RAW : 1;
    localparam logic signed [COORD_WIDTH-1:0] EPS_Q = COORD_WIDTH'(EPS_INT);
    localparam logic signed [COORD_WIDTH-1:0] ONE_Q =
        {{(COORD_WIDTH-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX =
        {{(ACC_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN =
        {{(ACC_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [PROD_WIDTH-1:0] FRAC_MASK =
        {{(PROD_WIDTH-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    // reciprocal: 2^(2F) / |det|, one quotient bit per cycle
    localparam int DIV_WIDTH = 2 * FRAC_BITS + 1;
    localparam int DIV_CNT_WIDTH = $clog2(DIV_WIDTH);
    localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(DIV_WIDTH - 1);

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIR_X    = 3'd3;

    // microcode step numbers where the sequencer branches
    localparam int STEP_WIDTH = 5;
    localparam logic [STEP_WIDTH-1:0] STEP_DET   = 5'd8;
    localparam logic [STEP_WIDTH-1:0] STEP_U     = 5'd12;
    localparam logic [STEP_WIDTH-1:0] STEP_V     = 5'd22;
    localparam logic [STEP_WIDTH-1:0] STEP_T     = 5'd26;
    localparam logic [STEP_WIDTH-1:0] STEP_LAST  = 5'd29;

    typedef enum logic [4:0] {
        OP_DIR0, OP_DIR1, OP_DIR2,
        OP_E1_0, OP_E1_1, OP_E1_2,
        OP_E2_0, OP_E2_1, OP_E2_2,
        OP_S0, OP_S1, OP_S2,
        OP_H0, OP_H1, OP_H2,
        OP_Q0, OP_Q1, OP_Q2,
        OP_F, OP_D, OP_T
    } opnd_t;

    typedef enum logic [1:0] {
        ACC_FIRST,
        ACC_ADD,
        ACC_SUB
    } acc_mode_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_H0, WB_H1, WB_H2,
        WB_DET, WB_D, WB_U, WB_V, WB_T,
        WB_Q0, WB_Q1, WB_Q2,
        WB_P0, WB_P1, WB_P2
    } wb_t;

    typedef struct packed {
        opnd_t     a;
        opnd_t     b;
        acc_mode_t mode;
        wb_t       wb;
    } uop_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex0_x;
        logic signed [COORD_WIDTH-1:0] vertex0_y;
        logic signed [COORD_WIDTH-1:0] vertex0_z;
        logic signed [COORD_WIDTH-1:0] vertex1_x;
        logic signed [COORD_WIDTH-1:0] vertex1_y;
        logic signed [COORD_WIDTH-1:0] vertex1_z;
        logic signed [COORD_WIDTH-1:0] vertex2_x;
        logic signed [COORD_WIDTH-1:0] vertex2_y;
        logic signed [COORD_WIDTH-1:0] vertex2_z;
        logic                          first_of_run;
        logic                          last_of_run;
    } tri_in_t;

    typedef struct packed {
        logic                          nearer_hit;
        logic [DIST_WIDTH-1:0]         hit_distance;
        logic                          best_found;
        logic [DIST_WIDTH-1:0]         best_distance;
        logic [INDEX_WIDTH-1:0]        best_index;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          run_done;
    } hit_out_t;

    function automatic uop_t ucode(input logic [STEP_WIDTH-1:0] step);
        uop_t u;
        u = '{a: OP_DIR0, b: OP_DIR0, mode: ACC_FIRST, wb: WB_NONE};
        unique case (step)
            // h = dir x e2
            5'd0:  u = '{a: OP_DIR1, b: OP_E2_2, mode: ACC_FIRST, wb: WB_NONE};
            5'd1:  u = '{a: OP_DIR2, b: OP_E2_1, mode: ACC_SUB,   wb: WB_H0};
            5'd2:  u = '{a: OP_DIR2, b: OP_E2_0, mode: ACC_FIRST, wb: WB_NONE};
            5'd3:  u = '{a: OP_DIR0, b: OP_E2_2, mode: ACC_SUB,   wb: WB_H1};
            5'd4:  u = '{a: OP_DIR0, b: OP_E2_1, mode: ACC_FIRST, wb: WB_NONE};
            5'd5:  u = '{a: OP_DIR1, b: OP_E2_0, mode: ACC_SUB,   wb: WB_H2};
            // det = h . e1
            5'd6:  u = '{a: OP_H0, b: OP_E1_0, mode: ACC_FIRST, wb: WB_NONE};
            5'd7:  u = '{a: OP_H1, b: OP_E1_1, mode: ACC_ADD,   wb: WB_NONE};
            5'd8:  u = '{a: OP_H2, b: OP_E1_2, mode: ACC_ADD,   wb: WB_DET};
            // u = f * (s . h)
            5'd9:  u = '{a: OP_S0, b: OP_H0, mode: ACC_FIRST, wb: WB_NONE};
            5'd10: u = '{a: OP_S1, b: OP_H1, mode: ACC_ADD,   wb: WB_NONE};
            5'd11: u = '{a: OP_S2, b: OP_H2, mode: ACC_ADD,   wb: WB_D};
            5'd12: u = '{a: OP_F,  b: OP_D,  mode: ACC_FIRST, wb: WB_U};
            // q = s x e1
            5'd13: u = '{a: OP_S1, b: OP_E1_2, mode: ACC_FIRST, wb: WB_NONE};
            5'd14: u = '{a: OP_S2, b: OP_E1_1, mode: ACC_SUB,   wb: WB_Q0};
            5'd15: u = '{a: OP_S2, b: OP_E1_0, mode: ACC_FIRST, wb: WB_NONE};
            5'd16: u = '{a: OP_S0, b: OP_E1_2, mode: ACC_SUB,   wb: WB_Q1};
            5'd17: u = '{a: OP_S0, b: OP_E1_1, mode: ACC_FIRST, wb: WB_NONE};
            5'd18: u = '{a: OP_S1, b: OP_E1_0, mode: ACC_SUB,   wb: WB_Q2};
            // v = f * (dir . q)
            5'd19: u = '{a: OP_DIR0, b: OP_Q0, mode: ACC_FIRST, wb: WB_NONE};
            5'd20: u = '{a: OP_DIR1, b: OP_Q1, mode: ACC_ADD,   wb: WB_NONE};
            5'd21: u = '{a: OP_DIR2, b: OP_Q2, mode: ACC_ADD,   wb: WB_D};
            5'd22: u = '{a: OP_F,    b: OP_D,  mode: ACC_FIRST, wb: WB_V};
            // t = f * (e2 . q)
            5'd23: u = '{a: OP_E2_0, b: OP_Q0, mode: ACC_FIRST, wb: WB_NONE};
            5'd24: u = '{a: OP_E2_1, b: OP_Q1, mode: ACC_ADD,   wb: WB_NONE};
            5'd25: u = '{a: OP_E2_2, b: OP_Q2, mode: ACC_ADD,   wb: WB_D};
            5'd26: u = '{a: OP_F,    b: OP_D,  mode: ACC_FIRST, wb: WB_T};
            // dir * t, origin added at the end
            5'd27: u = '{a: OP_DIR0, b: OP_T, mode: ACC_FIRST, wb: WB_P0};
            5'd28: u = '{a: OP_DIR1, b: OP_T, mode: ACC_FIRST, wb: WB_P1};
            5'd29: u = '{a: OP_DIR2, b: OP_T, mode: ACC_FIRST, wb: WB_P2};
            default: u = '{a: OP_DIR0, b: OP_DIR0, mode: ACC_FIRST, wb: WB_NONE};
        endcase
        return u;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_acc(
        input logic signed [ACC_WIDTH-1:0] x);
        logic signed [COORD_WIDTH-1:0] r;
        if (x > ACC_MAX)
            r = ACC_MAX[COORD_WIDTH-1:0];
        else if (x < ACC_MIN)
            r = ACC_MIN[COORD_WIDTH-1:0];
        else
            r = x[COORD_WIDTH-1:0];
        return r;
    endfunction

    // saturating a + b or a - b at coordinate width
    function automatic logic signed [COORD_WIDTH-1:0] sat_addsub(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b,
        input logic                          sub);
        logic signed [COORD_WIDTH:0] s;
        logic signed [COORD_WIDTH-1:0] r;
        s = sub ? ({a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b})
                : ({a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b});
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            r = s[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                               : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        else
            r = s[COORD_WIDTH-1:0];
        return r;
    endfunction

endpackage

@@ rtl/rtnh_if.sv @@
// ----------------------------------------------------------------------------
// rtnh channel interfaces
// Valid/ready channels for triangles, results and register writes.
// ----------------------------------------------------------------------------
interface rtnh_tri_if import rtnh_pkg::*; ();
    logic    valid;
    logic    ready;
    tri_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtnh_hit_if import rtnh_pkg::*; ();
    logic     valid;
    logic     ready;
    hit_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtnh_cfg_if import rtnh_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [CFG_IDX_WIDTH-1:0]      index;
    logic signed [COORD_WIDTH-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ray_triangle_nearest_hit_core.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_core
// Moller-Trumbore ray/triangle test with nearest-hit tracking, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   cfg      register writes (0..2 ray origin, 3..5 ray direction), always
//            ready; write only while the core is idle. Other indexes ignored.
//   triangle one beat per triangle: three vertices plus run marks. Ready is
//            high only while the sequencer is idle.
//   result   one beat per triangle: this triangle's t, the run's best hit
//            and the hit point, held in an output register.
// Timing: one 32x32 multiplier and one accumulator are shared by all 30
//   products; each product passes a multiply state, then an accumulate
//   state. The reciprocal of det comes from a restoring divider. A nearer
//   hit runs through all products; result valid rises in the same cycle
//   as the input is freed. A near-parallel triangle ends at the det step,
//   and u/v/t misses and farther hits end in between.
// Reset: ray registers go to zero, the run record to "no hit" (distance all
//   ones). A stalled result beat stays in the output register; the next
//   triangle is still taken and computed, then waits in its final state
//   with triangle ready low until the held beat leaves.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit_core import rtnh_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    rtnh_cfg_if.sink     cfg,
    rtnh_tri_if.sink     triangle,
    rtnh_hit_if.source   result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic signed [COORD_WIDTH-1:0] regs_reg [NUM_REGS];

    // per-triangle working set
    logic signed [COORD_WIDTH-1:0] e1_reg [3];
    logic signed [COORD_WIDTH-1:0] e2_reg [3];
    logic signed [COORD_WIDTH-1:0] s_reg  [3];
    logic signed [COORD_WIDTH-1:0] h_reg  [3];
    logic signed [COORD_WIDTH-1:0] q_reg  [3];
    logic signed [COORD_WIDTH-1:0] ps_reg [3];   // sat(dir * t)
    logic signed [COORD_WIDTH-1:0] det_reg, f_reg, d_reg, u_reg, t_reg;
    logic                          hit_reg;
    logic                          last_reg;
    logic [INDEX_WIDTH-1:0]        idx_reg;

    logic [STEP_WIDTH-1:0]         step_reg, step_next;
    logic signed [PROD_WIDTH-1:0]  prod_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg, acc_next;

    logic [COORD_WIDTH-1:0]        rem_reg;
    logic [DIV_WIDTH-1:0]          quo_reg;
    logic [DIV_CNT_WIDTH-1:0]      div_cnt_reg;

    // run record
    logic [DIST_WIDTH-1:0]         best_t_reg;
    logic                          found_reg;
    logic [INDEX_WIDTH-1:0]        best_idx_reg;
    logic [INDEX_WIDTH-1:0]        tri_cnt_reg;
    logic signed [COORD_WIDTH-1:0] best_pt_reg [3];

    logic                          out_valid_reg;
    hit_out_t                      out_reg;

    uop_t                          uop;
    logic signed [COORD_WIDTH-1:0] opa, opb;
    logic signed [PROD_WIDTH-1:0]  prod_rnd;
    logic signed [ACC_WIDTH-1:0]   term;
    logic signed [COORD_WIDTH-1:0] wb_val;
    logic                          tri_fire;
    logic                          fin_fire;
    logic                          nearer;
    logic [COORD_WIDTH-1:0]        dvs;
    logic [COORD_WIDTH:0]          div_sh;
    logic                          div_bit;
    logic [COORD_WIDTH:0]          div_diff;
    logic [DIV_WIDTH-1:0]          quo_next;
    logic signed [COORD_WIDTH-1:0] f_mag;
    logic signed [COORD_WIDTH:0]   uv_sum;
    logic                          det_small, u_bad, v_bad, t_ok;

    assign cfg.ready      = 1'b1;
    assign triangle.ready = (state_reg == S_IDLE);
    assign tri_fire       = triangle.valid && triangle.ready;
    assign fin_fire       = (state_reg == S_FIN) && (!out_valid_reg || result.ready);
    assign nearer         = hit_reg && (t_reg[DIST_WIDTH-1:0] < best_t_reg);

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // operand select for the shared multiplier
    function automatic logic signed [COORD_WIDTH-1:0] pick(input opnd_t sel);
        logic signed [COORD_WIDTH-1:0] r;
        unique case (sel)
            OP_DIR0: r = regs_reg[REG_DIR_X];
            OP_DIR1: r = regs_reg[REG_DIR_X + 3'd1];
            OP_DIR2: r = regs_reg[REG_DIR_X + 3'd2];
            OP_E1_0: r = e1_reg[0];
            OP_E1_1: r = e1_reg[1];
            OP_E1_2: r = e1_reg[2];
            OP_E2_0: r = e2_reg[0];
            OP_E2_1: r = e2_reg[1];
            OP_E2_2: r = e2_reg[2];
            OP_S0:   r = s_reg[0];
            OP_S1:   r = s_reg[1];
            OP_S2:   r = s_reg[2];
            OP_H0:   r = h_reg[0];
            OP_H1:   r = h_reg[1];
            OP_H2:   r = h_reg[2];
            OP_Q0:   r = q_reg[0];
            OP_Q1:   r = q_reg[1];
            OP_Q2:   r = q_reg[2];
            OP_F:    r = f_reg;
            OP_D:    r = d_reg;
            OP_T:    r = t_reg;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        uop = ucode(step_reg);
        opa = pick(uop.a);
        opb = pick(uop.b);
        // product >> FRAC_BITS, truncated toward zero
        prod_rnd = prod_reg + (prod_reg[PROD_WIDTH-1] ? $signed(FRAC_MASK) : '0);
        term = ACC_WIDTH'(prod_rnd >>> FRAC_BITS);
        unique case (uop.mode)
            ACC_FIRST: acc_next = term;
            ACC_ADD:   acc_next = acc_reg + term;
            ACC_SUB:   acc_next = acc_reg - term;
            default:   acc_next = term;
        endcase
        wb_val = sat_acc(acc_next);

        det_small = (wb_val > -EPS_Q) && (wb_val < EPS_Q);
        u_bad     = wb_val[COORD_WIDTH-1] || (wb_val > ONE_Q);
        uv_sum    = {u_reg[COORD_WIDTH-1], u_reg} + {wb_val[COORD_WIDTH-1], wb_val};
        v_bad     = wb_val[COORD_WIDTH-1] ||
                    (uv_sum > $signed({ONE_Q[COORD_WIDTH-1], ONE_Q}));
        t_ok      = wb_val > EPS_Q;

        // restoring divider step
        dvs      = det_reg[COORD_WIDTH-1] ? COORD_WIDTH'(-det_reg) : COORD_WIDTH'(det_reg);
        div_sh   = {rem_reg, (div_cnt_reg == '0)};
        div_diff = div_sh - {1'b0, dvs};
        div_bit  = (div_sh >= {1'b0, dvs});
        quo_next = {quo_reg[DIV_WIDTH-2:0], div_bit};
        if (quo_next > DIV_WIDTH'({(COORD_WIDTH-1){1'b1}}))
            f_mag = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        else
            f_mag = COORD_WIDTH'(quo_next);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tri_fire)
                begin
                    state_next = S_MUL;
                    step_next  = '0;
                end
            end
            S_MUL:
                state_next = S_ACC;
            S_ACC:
            begin
                state_next = S_MUL;
                step_next  = step_reg + 1'b1;
                priority if (step_reg == STEP_DET)
                    state_next = det_small ? S_FIN : S_DIV;
                else if (step_reg == STEP_U && u_bad)
                    state_next = S_FIN;
                else if (step_reg == STEP_V && v_bad)
                    state_next = S_FIN;
                else if (step_reg == STEP_T &&
                         !(t_ok && wb_val[DIST_WIDTH-1:0] < best_t_reg))
                    state_next = S_FIN;
                else if (step_reg == STEP_LAST)
                    state_next = S_FIN;
                else
                    state_next = S_MUL;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_MUL;
            end
            S_FIN:
            begin
                if (fin_fire)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            best_t_reg    <= '1;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            tri_cnt_reg   <= '0;
            for (int k = 0; k < 3; k++)
                best_pt_reg[k] <= '0;
            for (int k = 0; k < NUM_REGS; k++)
                regs_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg.valid && cfg.ready && cfg.index < CFG_IDX_WIDTH'(NUM_REGS))
                regs_reg[cfg.index] <= cfg.data;

            if (tri_fire)
            begin
                hit_reg     <= 1'b0;
                div_cnt_reg <= '0;
                if (triangle.data.first_of_run)
                begin
                    best_t_reg   <= '1;
                    found_reg    <= 1'b0;
                    best_idx_reg <= '0;
                    tri_cnt_reg  <= INDEX_WIDTH'(1);
                    for (int k = 0; k < 3; k++)
                        best_pt_reg[k] <= '0;
                end
                else
                    tri_cnt_reg <= tri_cnt_reg + 1'b1;
            end

            if (state_reg == S_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;

            if (state_reg == S_ACC && step_reg == STEP_T)
                hit_reg <= t_ok;

            if (fin_fire && nearer)
            begin
                best_t_reg   <= t_reg[DIST_WIDTH-1:0];
                found_reg    <= 1'b1;
                best_idx_reg <= idx_reg;
                for (int k = 0; k < 3; k++)
                    best_pt_reg[k] <= sat_addsub(regs_reg[REG_ORIGIN_X + 3'(k)],
                                                 ps_reg[k], 1'b0);
            end

            if (fin_fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (tri_fire)
        begin
            e1_reg[0] <= sat_addsub(triangle.data.vertex1_x, triangle.data.vertex0_x, 1'b1);
            e1_reg[1] <= sat_addsub(triangle.data.vertex1_y, triangle.data.vertex0_y, 1'b1);
            e1_reg[2] <= sat_addsub(triangle.data.vertex1_z, triangle.data.vertex0_z, 1'b1);
            e2_reg[0] <= sat_addsub(triangle.data.vertex2_x, triangle.data.vertex0_x, 1'b1);
            e2_reg[1] <= sat_addsub(triangle.data.vertex2_y, triangle.data.vertex0_y, 1'b1);
            e2_reg[2] <= sat_addsub(triangle.data.vertex2_z, triangle.data.vertex0_z, 1'b1);
            s_reg[0]  <= sat_addsub(regs_reg[REG_ORIGIN_X], triangle.data.vertex0_x, 1'b1);
            s_reg[1]  <= sat_addsub(regs_reg[REG_ORIGIN_X + 3'd1],
                                    triangle.data.vertex0_y, 1'b1);
            s_reg[2]  <= sat_addsub(regs_reg[REG_ORIGIN_X + 3'd2],
                                    triangle.data.vertex0_z, 1'b1);
            last_reg  <= triangle.data.last_of_run;
            idx_reg   <= triangle.data.first_of_run ? '0 : tri_cnt_reg;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end

        if (state_reg == S_MUL)
            prod_reg <= opa * opb;

        if (state_reg == S_ACC)
        begin
            acc_reg <= acc_next;
            unique case (uop.wb)
                WB_NONE: ;
                WB_H0:   h_reg[0]  <= wb_val;
                WB_H1:   h_reg[1]  <= wb_val;
                WB_H2:   h_reg[2]  <= wb_val;
                WB_DET:  det_reg   <= wb_val;
                WB_D:    d_reg     <= wb_val;
                WB_U:    u_reg     <= wb_val;
                WB_V:    ;
                WB_T:    t_reg     <= wb_val;
                WB_Q0:   q_reg[0]  <= wb_val;
                WB_Q1:   q_reg[1]  <= wb_val;
                WB_Q2:   q_reg[2]  <= wb_val;
                WB_P0:   ps_reg[0] <= wb_val;
                WB_P1:   ps_reg[1] <= wb_val;
                WB_P2:   ps_reg[2] <= wb_val;
                default: ;
            endcase
        end

        if (state_reg == S_DIV)
        begin
            rem_reg <= div_bit ? div_diff[COORD_WIDTH-1:0] : div_sh[COORD_WIDTH-1:0];
            quo_reg <= quo_next;
            if (div_cnt_reg == DIV_LAST)
                f_reg <= det_reg[COORD_WIDTH-1] ? -f_mag : f_mag;
        end

        if (fin_fire)
        begin
            out_reg.nearer_hit    <= nearer;
            out_reg.hit_distance  <= hit_reg ? t_reg[DIST_WIDTH-1:0] : '0;
            out_reg.best_found    <= found_reg || nearer;
            out_reg.best_distance <= nearer ? t_reg[DIST_WIDTH-1:0] : best_t_reg;
            out_reg.best_index    <= nearer ? idx_reg : best_idx_reg;
            out_reg.point_x <= nearer ? sat_addsub(regs_reg[REG_ORIGIN_X], ps_reg[0], 1'b0)
                                      : best_pt_reg[0];
            out_reg.point_y <= nearer ? sat_addsub(regs_reg[REG_ORIGIN_X + 3'd1],
                                                   ps_reg[1], 1'b0)
                                      : best_pt_reg[1];
            out_reg.point_z <= nearer ? sat_addsub(regs_reg[REG_ORIGIN_X + 3'd2],
                                                   ps_reg[2], 1'b0)
                                      : best_pt_reg[2];
            out_reg.run_done      <= last_reg;
        end
    end

    // an accepted triangle always starts the multiply sequence
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        tri_fire |=> (state_reg == S_MUL) && (step_reg == '0))
        else $error("triangle accepted without starting the sequence");

    // microcode never runs past the point steps
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_ACC) |-> (step_reg <= STEP_LAST))
        else $error("microcode step out of range");

    // divider only ever sees a determinant at least epsilon away from zero
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dvs >= COORD_WIDTH'(EPS_Q)))
        else $error("reciprocal of a near-zero determinant");

    // an empty run record keeps the maximum distance
    a_record: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> (best_t_reg == '1))
        else $error("run record distance set without a hit");

endmodule

@@ tb/rtnh_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_tb_if
// Failure, pending and nearer-hit count carrier between the scoreboard checker and the test top.
// ----------------------------------------------------------------------------
interface rtnh_tb_if ();
    int fails;
    int pending;
    int hits_seen;
    modport source (output fails, output pending, output hits_seen);
    modport sink   (input fails, input pending, input hits_seen);
endinterface

@@ tb/rtnh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtnh_checker
// Watches the config, triangle and result channels, models the nearest-hit
// ray/triangle test and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module rtnh_checker import rtnh_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    rtnh_cfg_if.sink   cfg,
    rtnh_tri_if.sink   triangle,
    rtnh_hit_if.sink   result,
    rtnh_tb_if.source  stat
);
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam longint CAP    = (64'sd1 <<< 60) - 1;
    localparam longint EPS    = EPS_INT;
    localparam longint ONE    = 64'sd1 <<< FRAC_BITS;

    longint   ray_reg [NUM_REGS];
    longint   best_t;
    logic     best_ok;
    logic [INDEX_WIDTH-1:0] best_idx;
    logic [INDEX_WIDTH-1:0] tri_cnt;
    longint   best_pt [3];
    hit_out_t hit_queue [$];

    function automatic longint clip(input longint x);
        return x > SAT_HI ? SAT_HI : (x < SAT_LO ? SAT_LO : x);
    endfunction

    // product truncated toward zero to Q.F, magnitude capped
    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0]  ua, ub;
        longint       r;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = (ua * 128'd1) * ub;
        p = p >> FRAC_BITS;
        r = (p > CAP) ? CAP : longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint dot(input longint a0, a1, a2, b0, b1, b2);
        return clip(qmul(a0, b0) + qmul(a1, b1) + qmul(a2, b2));
    endfunction

    function automatic logic tri_hit(input tri_in_t tr, output longint t_out);
        longint v [9];
        longint e1 [3], e2 [3], s [3], h [3], q [3];
        longint det, f, u, vv, t, fm;
        logic [63:0] dm;
        v = '{tr.vertex0_x, tr.vertex0_y, tr.vertex0_z,
              tr.vertex1_x, tr.vertex1_y, tr.vertex1_z,
              tr.vertex2_x, tr.vertex2_y, tr.vertex2_z};
        t_out = 0;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = clip(v[3+k] - v[k]);
            e2[k] = clip(v[6+k] - v[k]);
            s[k]  = clip(ray_reg[k] - v[k]);
        end
        h[0] = clip(qmul(ray_reg[4], e2[2]) - qmul(ray_reg[5], e2[1]));
        h[1] = clip(qmul(ray_reg[5], e2[0]) - qmul(ray_reg[3], e2[2]));
        h[2] = clip(qmul(ray_reg[3], e2[1]) - qmul(ray_reg[4], e2[0]));
        det = dot(h[0], h[1], h[2], e1[0], e1[1], e1[2]);
        if (det > -EPS && det < EPS)
            return 1'b0;
        dm = det < 0 ? -det : det;
        fm = longint'((64'd1 << (2 * FRAC_BITS)) / dm);
        if (fm > SAT_HI)
            fm = SAT_HI;
        f = det < 0 ? -fm : fm;
        u = clip(qmul(f, dot(s[0], s[1], s[2], h[0], h[1], h[2])));
        if (u < 0 || u > ONE)
            return 1'b0;
        q[0] = clip(qmul(s[1], e1[2]) - qmul(s[2], e1[1]));
        q[1] = clip(qmul(s[2], e1[0]) - qmul(s[0], e1[2]));
        q[2] = clip(qmul(s[0], e1[1]) - qmul(s[1], e1[0]));
        vv = clip(qmul(f, dot(ray_reg[3], ray_reg[4], ray_reg[5], q[0], q[1], q[2])));
        if (vv < 0 || u + vv > ONE)
            return 1'b0;
        t = clip(qmul(f, dot(e2[0], e2[1], e2[2], q[0], q[1], q[2])));
        if (t <= EPS)
            return 1'b0;
        t_out = t;
        return 1'b1;
    endfunction

    function automatic void clear_record();
        best_t = SAT_HI;
        best_ok = 1'b0;
        best_idx = '0;
        tri_cnt = '0;
        best_pt = '{0, 0, 0};
    endfunction

    function automatic hit_out_t predict_hit(input tri_in_t tr);
        hit_out_t r;
        longint   t;
        logic     hit, nearer;
        logic [INDEX_WIDTH-1:0] idx;
        if (tr.first_of_run)
            clear_record();
        idx = tri_cnt;
        tri_cnt = tri_cnt + 1'b1;
        hit = tri_hit(tr, t);
        nearer = hit && t < best_t;
        if (nearer)
        begin
            best_t = t;
            best_ok = 1'b1;
            best_idx = idx;
            for (int k = 0; k < 3; k++)
                best_pt[k] = clip(ray_reg[k] + clip(qmul(ray_reg[3+k], t)));
        end
        r.nearer_hit    = nearer;
        r.hit_distance  = hit ? DIST_WIDTH'(t) : '0;
        r.best_found    = best_ok;
        r.best_distance = DIST_WIDTH'(best_t);
        r.best_index    = best_idx;
        r.point_x       = COORD_WIDTH'(best_pt[0]);
        r.point_y       = COORD_WIDTH'(best_pt[1]);
        r.point_z       = COORD_WIDTH'(best_pt[2]);
        r.run_done      = tr.last_of_run;
        return r;
    endfunction

    task automatic chk(input string nm, input longint e, input longint a);
        if (e != a)
        begin
            $error("%s mismatch: expected %0h got %0h", nm, e, a);
            stat.fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hit_out_t e, a;
        if (!rst_n)
        begin
            foreach (ray_reg[k]) ray_reg[k] = 0;
            clear_record();
            hit_queue.delete();
            stat.fails = 0;
            stat.pending = 0;
            stat.hits_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready && cfg.index < NUM_REGS)
                ray_reg[cfg.index] = longint'(cfg.data);
            if (triangle.valid && triangle.ready)
                hit_queue.insert(hit_queue.size(), predict_hit(triangle.data));
            if (result.valid && result.ready)
            begin
                a = result.data;
                if (hit_queue.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    stat.fails++;
                end
                else
                begin
                    e = hit_queue.pop_front();
                    if (e.nearer_hit) stat.hits_seen++;
                    chk("nearer_hit", e.nearer_hit, a.nearer_hit);
                    chk("hit_distance", e.hit_distance, a.hit_distance);
                    chk("best_found", e.best_found, a.best_found);
                    chk("best_distance", e.best_distance, a.best_distance);
                    chk("best_index", e.best_index, a.best_index);
                    chk("point_x", e.point_x, a.point_x);
                    chk("point_y", e.point_y, a.point_y);
                    chk("point_z", e.point_z, a.point_z);
                    chk("run_done", e.run_done, a.run_done);
                end
            end
            stat.pending = hit_queue.size();
        end
    end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ray setups and triangle streams into the nearest-hit core with random
// gaps and result back-pressure; the checker predicts and compares each beat.
// ----------------------------------------------------------------------------
module tb_top;
    import rtnh_pkg::*;

    localparam int N_RANDOM = 1950;
    localparam int N_PHASES = 8;

    logic clk;
    logic rst_n;

    rtnh_cfg_if cfg ();
    rtnh_tri_if triangle ();
    rtnh_hit_if result ();
    rtnh_tb_if  stat ();

    // long receiver hold-off requested by the stimulus process
    logic hold_req;
    int   n_sent;

    ray_triangle_nearest_hit_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg.sink),
        .triangle (triangle.sink),
        .result   (result.source)
    );

    rtnh_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg.sink),
        .triangle (triangle.sink),
        .result   (result.sink),
        .stat     (stat.source)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: time for every triangle's sequence plus gaps and stalls, many times over
    initial
    begin
        #60ms;
        $display("[ray_triangle_nearest_hit_core] ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // coordinate mix: small Q16.16 values mostly, full range sometimes
    function automatic logic [31:0] rnd_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        if (r < 8) return $urandom;
        return r == 8 ? 32'h7fffffff : 32'h80000000;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                result.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] v);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // wait for every outstanding result, then let the core settle
    task automatic drain();
        while (stat.pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic send_tri(input tri_in_t t);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            triangle.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        triangle.valid <= 1'b1;
        triangle.data  <= t;
        @(posedge clk);
        while (!triangle.ready) @(posedge clk);
        n_sent++;
    endtask

    task automatic idle_tri();
        triangle.valid <= 1'b0;
        @(posedge clk);
    endtask

    // triangle straddling the ray at distance d along +z in a plane facing it
    function automatic tri_in_t hit_tri(input int d, input logic fr, input logic ls);
        tri_in_t t;
        int sz;
        sz = $urandom_range(1, 8) << 16;
        t.vertex0_x = -sz;  t.vertex0_y = -sz;  t.vertex0_z = d;
        t.vertex1_x =  sz * 2; t.vertex1_y = -sz;  t.vertex1_z = d;
        t.vertex2_x = -sz;  t.vertex2_y =  sz * 2; t.vertex2_z = d;
        if ($urandom_range(0, 1))
        begin
            t.vertex0_x += $urandom_range(0, 65535) - 32768;
            t.vertex2_z += $urandom_range(0, 65535) - 32768;
        end
        t.first_of_run = fr;
        t.last_of_run  = ls;
        return t;
    endfunction

    function automatic tri_in_t noise_tri();
        tri_in_t t;
        t.vertex0_x = rnd_coord(); t.vertex0_y = rnd_coord(); t.vertex0_z = rnd_coord();
        t.vertex1_x = rnd_coord(); t.vertex1_y = rnd_coord(); t.vertex1_z = rnd_coord();
        t.vertex2_x = rnd_coord(); t.vertex2_y = rnd_coord(); t.vertex2_z = rnd_coord();
        t.first_of_run = $urandom_range(0, 7) == 0;
        t.last_of_run  = $urandom_range(0, 7) == 0;
        return t;
    endfunction

    // ray along +z from the origin, all-extreme registers, or a random near-+z ray
    task automatic set_ray(input int kind);
        if (kind == 0)
        begin
            write_reg(REG_ORIGIN_X, '0); write_reg(REG_ORIGIN_X + 3'd1, '0);
            write_reg(REG_ORIGIN_X + 3'd2, '0);
            write_reg(REG_DIR_X, '0); write_reg(REG_DIR_X + 3'd1, '0);
            write_reg(REG_DIR_X + 3'd2, 32'h0001_0000);
        end
        else if (kind == 1)
        begin
            for (int k = 0; k < 3; k++) write_reg(REG_ORIGIN_X + 3'(k), 32'h7fffffff);
            for (int k = 0; k < 3; k++) write_reg(REG_DIR_X + 3'(k), 32'h80000000);
        end
        else
        begin
            write_reg(REG_ORIGIN_X, $urandom_range(0, 65535) - 32768);
            write_reg(REG_ORIGIN_X + 3'd1, $urandom_range(0, 65535) - 32768);
            write_reg(REG_ORIGIN_X + 3'd2, -($urandom_range(0, 4) << 16));
            write_reg(REG_DIR_X, $urandom_range(0, 8191) - 4096);
            write_reg(REG_DIR_X + 3'd1, $urandom_range(0, 8191) - 4096);
            write_reg(REG_DIR_X + 3'd2, $urandom_range(1 << 14, 3 << 16));
        end
    endtask

    initial
    begin
        tri_in_t t;
        int run_len, pos;
        rst_n = 1'b0;
        hold_req = 1'b0;
        n_sent = 0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        triangle.valid = 1'b0; triangle.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset-state ray (zero direction => parallel), then basics
        send_tri(hit_tri(5 << 16, 1'b1, 1'b0));
        idle_tri();
        drain();
        set_ray(0);
        send_tri(hit_tri(5 << 16, 1'b1, 1'b0));           // plain hit
        send_tri(hit_tri(9 << 16, 1'b0, 1'b0));           // farther: no replace
        send_tri(hit_tri(5 << 16, 1'b0, 1'b0));           // equal distance
        send_tri(hit_tri(2 << 16, 1'b0, 1'b0));           // nearer
        send_tri(hit_tri(-(3 << 16), 1'b0, 1'b0));        // behind origin
        send_tri(hit_tri(4, 1'b0, 1'b0));                 // t below epsilon
        t = hit_tri(3 << 16, 1'b0, 1'b0);
        t.vertex0_x += 20 << 16; t.vertex1_x += 20 << 16; t.vertex2_x += 20 << 16;
        send_tri(t);                                      // outside triangle
        t = hit_tri(3 << 16, 1'b0, 1'b0);
        t.vertex2_z = t.vertex0_z; t.vertex2_x = t.vertex0_x; t.vertex2_y = t.vertex0_y;
        send_tri(t);                                      // degenerate, parallel
        send_tri(hit_tri(32'h7fff0000, 1'b0, 1'b1));      // huge t, saturates
        send_tri(hit_tri(32'h7fff0000, 1'b1, 1'b0));      // saturated t on fresh run
        t = noise_tri(); t.first_of_run = 1'b0; t.last_of_run = 1'b1;
        send_tri(t);
        t.vertex0_x = 32'h80000000; t.vertex1_x = 32'h7fffffff; t.vertex2_x = 32'h80000000;
        t.vertex0_y = 32'h7fffffff; t.vertex1_y = 32'h80000000; t.vertex2_y = 32'h7fffffff;
        send_tri(t);                                      // extreme vertices
        idle_tri();
        drain();
        set_ray(1);                                       // extreme register values
        send_tri(noise_tri());
        send_tri(hit_tri(1 << 16, 1'b1, 1'b1));
        idle_tri();
        drain();

        // random phases: well-formed runs mostly, noise in between
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_ray(ph == N_PHASES - 1 ? 1 : (ph == 0 ? 0 : 2));
            if (ph == 2)
                hold_req <= 1'b1;                         // fill up behind a stalled result
            for (int i = 0; i < N_RANDOM / N_PHASES; i++)
            begin
                if (ph == 2 && i >= 4)
                    hold_req <= 1'b0;
                if ($urandom_range(0, 4) == 0)
                    send_tri(noise_tri());
                else
                begin
                    run_len = $urandom_range(1, 8);
                    for (pos = 0; pos < run_len; pos++)
                    begin
                        send_tri(hit_tri($urandom_range(4, 40 << 16),
                                         pos == 0, pos == run_len - 1));
                        if (pos > 0)
                            i++;
                    end
                end
            end
            idle_tri();
            drain();                                      // sender pauses until all results come
        end

        $display("covered %0d triangles over %0d ray setups, %0d nearer hits",
                 n_sent, N_PHASES + 3, stat.hits_seen);
        if (stat.fails == 0)
            $display("[ray_triangle_nearest_hit_core] OK");
        else
            $display("[ray_triangle_nearest_hit_core] ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/rtnh_pkg.sv
rtl/rtnh_if.sv
rtl/ray_triangle_nearest_hit_core.sv
tb/rtnh_tb_if.sv
tb/rtnh_checker.sv
tb/tb_top.sv
